@@ rtl/core/i2p_pkg.sv @@
// ----------------------------------------------------------------------------
// i2p_pkg
// Shared types, character constants and operator tables for the infix to
// postfix converter.
// ----------------------------------------------------------------------------
package i2p_pkg;

   localparam int STACK_DEPTH_DEFAULT = 32;

   localparam logic [7:0] CHR_PLUS    = 8'h2B;
   localparam logic [7:0] CHR_MINUS   = 8'h2D;
   localparam logic [7:0] CHR_STAR    = 8'h2A;
   localparam logic [7:0] CHR_SLASH   = 8'h2F;
   localparam logic [7:0] CHR_CARET   = 8'h5E;
   localparam logic [7:0] CHR_OPEN    = 8'h28;
   localparam logic [7:0] CHR_CLOSE   = 8'h29;
   localparam logic [7:0] CHR_LOWER_A = 8'h61;
   localparam logic [7:0] CHR_LOWER_Z = 8'h7A;
   localparam logic [7:0] CHR_UPPER_A = 8'h41;
   localparam logic [7:0] CHR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHR_NUL     = 8'h00;

   typedef enum logic [2:0] {
      CODE_OPEN  = 3'd0,
      CODE_PLUS  = 3'd1,
      CODE_MINUS = 3'd2,
      CODE_MUL   = 3'd3,
      CODE_DIV   = 3'd4,
      CODE_POW   = 3'd5
   } op_code_type;

   typedef enum logic [2:0] {
      ERR_NONE            = 3'd0,
      ERR_UNMATCHED_CLOSE = 3'd1,
      ERR_OVERFLOW        = 3'd2,
      ERR_UNKNOWN         = 3'd3,
      ERR_UNCLOSED_OPEN   = 3'd4
   } err_code_type;

   typedef enum logic [1:0] {
      STK_HOLD = 2'd0,
      STK_PUSH = 2'd1,
      STK_POP  = 2'd2
   } stack_op_type;

   typedef struct packed {
      stack_op_type op;
      op_code_type  code;
   } stack_cmd_type;

   typedef enum logic [1:0] {
      S_IDLE  = 2'd0,
      S_CHAR  = 2'd1,
      S_FLUSH = 2'd2,
      S_LAST  = 2'd3
   } state_type;

   function automatic op_code_type char_to_code(input logic [7:0] chr);
      op_code_type code;
      code = CODE_OPEN;
      priority case (chr)
         CHR_PLUS:  code = CODE_PLUS;
         CHR_MINUS: code = CODE_MINUS;
         CHR_STAR:  code = CODE_MUL;
         CHR_SLASH: code = CODE_DIV;
         CHR_CARET: code = CODE_POW;
         default:   code = CODE_OPEN;
      endcase
      return code;
   endfunction

   function automatic logic [7:0] code_to_char(input op_code_type code);
      logic [7:0] chr;
      chr = CHR_OPEN;
      unique case (code)
         CODE_OPEN:  chr = CHR_OPEN;
         CODE_PLUS:  chr = CHR_PLUS;
         CODE_MINUS: chr = CHR_MINUS;
         CODE_MUL:   chr = CHR_STAR;
         CODE_DIV:   chr = CHR_SLASH;
         CODE_POW:   chr = CHR_CARET;
         default:    chr = CHR_OPEN;
      endcase
      return chr;
   endfunction

   function automatic logic [1:0] code_prec(input op_code_type code);
      logic [1:0] prec;
      prec = 2'd0;
      unique case (code)
         CODE_OPEN:  prec = 2'd0;
         CODE_PLUS:  prec = 2'd1;
         CODE_MINUS: prec = 2'd1;
         CODE_MUL:   prec = 2'd2;
         CODE_DIV:   prec = 2'd2;
         CODE_POW:   prec = 2'd3;
         default:    prec = 2'd0;
      endcase
      return prec;
   endfunction

endpackage

@@ rtl/core/i2p_req_if.sv @@
// ----------------------------------------------------------------------------
// i2p_req_if
// Request channel: one infix character word with its end flag.
// ----------------------------------------------------------------------------
interface i2p_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] symbol;
   logic       end_of_expression;

   modport source (output valid, output symbol, output end_of_expression, input ready);
   modport sink   (input valid, input symbol, input end_of_expression, output ready);
endinterface

@@ rtl/core/i2p_rsp_if.sv @@
// ----------------------------------------------------------------------------
// i2p_rsp_if
// Response channel: one postfix result word with status.
// ----------------------------------------------------------------------------
interface i2p_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_symbol;
   logic       symbol_valid;
   logic       expression_done;
   logic [2:0] error_code;

   modport source (output valid, output out_symbol, output symbol_valid,
                   output expression_done, output error_code, input ready);
   modport sink   (input valid, input out_symbol, input symbol_valid,
                   input expression_done, input error_code, output ready);
endinterface

@@ rtl/core/i2p_cell.sv @@
// ----------------------------------------------------------------------------
// i2p_cell
// One operator stack entry; shifts towards the top on pop and away from it
// on push.
// ----------------------------------------------------------------------------
module i2p_cell (
   input  logic                  clock,
   input  i2p_pkg::stack_cmd_type stack_cmd,
   input  i2p_pkg::op_code_type  from_above,
   input  i2p_pkg::op_code_type  from_below,
   output i2p_pkg::op_code_type  value
);
   import i2p_pkg::*;

   op_code_type value_ff;
   op_code_type value_in;

   always_comb begin
      unique case (stack_cmd.op)
         STK_PUSH: value_in = from_above;
         STK_POP:  value_in = from_below;
         default:  value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;

endmodule

@@ rtl/core/i2p_ctrl.sv @@
// ----------------------------------------------------------------------------
// i2p_ctrl
// Sequencer for the shunting-yard steps: classifies the character, drives
// the stack chain at most one push or pop a cycle and stages result words.
// ----------------------------------------------------------------------------
module i2p_ctrl #(
   parameter int STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   i2p_req_if.sink                req_chan,
   i2p_rsp_if.source              rsp_chan,
   input  i2p_pkg::op_code_type   stack_top,
   output i2p_pkg::stack_cmd_type stack_cmd
);
   import i2p_pkg::*;

   localparam int CNT_W = $clog2(STACK_DEPTH + 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(STACK_DEPTH);

   state_type        state_ff, state_in;
   logic [7:0]       sym_ff, sym_in;
   logic             end_ff, end_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             open_left_ff, open_left_in;
   logic             hold_valid_ff, hold_valid_in;
   logic [7:0]       hold_sym_ff, hold_sym_in;
   logic             hold_sv_ff, hold_sv_in;
   err_code_type     hold_err_ff, hold_err_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_sym_ff, rsp_sym_in;
   logic             rsp_sv_ff, rsp_sv_in;
   logic             rsp_done_ff, rsp_done_in;
   err_code_type     rsp_err_ff, rsp_err_in;

   logic             accept;
   logic             out_free;
   logic             can_emit;
   logic             emit_req;
   logic             fire;
   logic [7:0]       emit_sym;
   logic             emit_sv;
   err_code_type     emit_err;
   logic             step_done;
   logic             set_open;
   logic             last_load;
   logic             out_load;
   logic             empty;
   logic             full;
   logic             is_letter;
   op_code_type      in_code;
   logic             top_pops;

   assign accept    = req_chan.valid && req_chan.ready;
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;
   assign can_emit  = !hold_valid_ff || out_free;
   assign fire      = emit_req && can_emit;
   assign empty     = (count_ff == '0);
   assign full      = (count_ff == CNT_FULL);
   assign is_letter = ((sym_ff >= CHR_LOWER_A) && (sym_ff <= CHR_LOWER_Z)) ||
                      ((sym_ff >= CHR_UPPER_A) && (sym_ff <= CHR_UPPER_Z));
   assign in_code   = char_to_code(sym_ff);
   assign top_pops  = !empty && (stack_top != CODE_OPEN) &&
                      (code_prec(stack_top) >= code_prec(in_code));

   // step decisions and stack commands
   always_comb begin
      emit_req       = 1'b0;
      emit_sym       = CHR_NUL;
      emit_sv        = 1'b0;
      emit_err       = ERR_NONE;
      stack_cmd.op   = STK_HOLD;
      stack_cmd.code = CODE_OPEN;
      step_done      = 1'b0;
      set_open       = 1'b0;
      last_load      = 1'b0;
      unique case (state_ff)
         S_CHAR: begin
            if (is_letter) begin
               emit_req  = 1'b1;
               emit_sym  = sym_ff;
               emit_sv   = 1'b1;
               step_done = can_emit;
            end else if (sym_ff == CHR_OPEN) begin
               if (full) begin
                  emit_req  = 1'b1;
                  emit_err  = ERR_OVERFLOW;
                  step_done = can_emit;
               end else begin
                  stack_cmd.op   = STK_PUSH;
                  stack_cmd.code = CODE_OPEN;
                  step_done      = 1'b1;
               end
            end else if (sym_ff == CHR_CLOSE) begin
               if (empty) begin
                  emit_req  = 1'b1;
                  emit_err  = ERR_UNMATCHED_CLOSE;
                  step_done = can_emit;
               end else if (stack_top == CODE_OPEN) begin
                  stack_cmd.op = STK_POP;
                  step_done    = 1'b1;
               end else begin
                  emit_req = 1'b1;
                  emit_sym = code_to_char(stack_top);
                  emit_sv  = 1'b1;
                  if (can_emit) stack_cmd.op = STK_POP;
               end
            end else if (in_code != CODE_OPEN) begin
               if (top_pops) begin
                  emit_req = 1'b1;
                  emit_sym = code_to_char(stack_top);
                  emit_sv  = 1'b1;
                  if (can_emit) stack_cmd.op = STK_POP;
               end else if (full) begin
                  emit_req  = 1'b1;
                  emit_err  = ERR_OVERFLOW;
                  step_done = can_emit;
               end else begin
                  stack_cmd.op   = STK_PUSH;
                  stack_cmd.code = in_code;
                  step_done      = 1'b1;
               end
            end else begin
               emit_req  = 1'b1;
               emit_err  = ERR_UNKNOWN;
               step_done = can_emit;
            end
         end
         S_FLUSH: begin
            if (empty) begin
               if (open_left_ff) begin
                  emit_req  = 1'b1;
                  emit_err  = ERR_UNCLOSED_OPEN;
                  step_done = can_emit;
               end else begin
                  step_done = 1'b1;
               end
            end else if (stack_top == CODE_OPEN) begin
               stack_cmd.op = STK_POP;
               set_open     = 1'b1;
            end else begin
               emit_req = 1'b1;
               emit_sym = code_to_char(stack_top);
               emit_sv  = 1'b1;
               if (can_emit) stack_cmd.op = STK_POP;
            end
         end
         S_LAST: begin
            if (hold_valid_ff || end_ff) begin
               last_load = out_free;
               step_done = out_free;
            end else begin
               step_done = 1'b1;
            end
         end
         default: begin
            step_done = 1'b0;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE:  if (accept) state_in = S_CHAR;
         S_CHAR:  if (step_done) state_in = end_ff ? S_FLUSH : S_LAST;
         S_FLUSH: if (step_done) state_in = S_LAST;
         S_LAST:  if (step_done) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // datapath next values
   always_comb begin
      sym_in        = accept ? req_chan.symbol : sym_ff;
      end_in        = accept ? req_chan.end_of_expression : end_ff;
      open_left_in  = accept ? 1'b0 : (open_left_ff || set_open);
      count_in      = count_ff;
      unique case (stack_cmd.op)
         STK_PUSH: count_in = count_ff + CNT_W'(1);
         STK_POP:  count_in = count_ff - CNT_W'(1);
         default:  count_in = count_ff;
      endcase

      hold_valid_in = hold_valid_ff;
      hold_sym_in   = hold_sym_ff;
      hold_sv_in    = hold_sv_ff;
      hold_err_in   = hold_err_ff;
      if (fire) begin
         hold_valid_in = 1'b1;
         hold_sym_in   = emit_sym;
         hold_sv_in    = emit_sv;
         hold_err_in   = emit_err;
      end else if (last_load) begin
         hold_valid_in = 1'b0;
      end

      out_load    = (fire && hold_valid_ff) || last_load;
      rsp_sym_in  = rsp_sym_ff;
      rsp_sv_in   = rsp_sv_ff;
      rsp_done_in = rsp_done_ff;
      rsp_err_in  = rsp_err_ff;
      if (last_load && !hold_valid_ff) begin
         rsp_sym_in  = CHR_NUL;
         rsp_sv_in   = 1'b0;
         rsp_done_in = 1'b1;
         rsp_err_in  = ERR_NONE;
      end else if (out_load) begin
         rsp_sym_in  = hold_sym_ff;
         rsp_sv_in   = hold_sv_ff;
         rsp_done_in = last_load && end_ff;
         rsp_err_in  = hold_err_ff;
      end
      rsp_valid_in = out_load ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         open_left_ff  <= 1'b0;
         hold_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         open_left_ff  <= open_left_in;
         hold_valid_ff <= hold_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sym_ff      <= sym_in;
      end_ff      <= end_in;
      hold_sym_ff <= hold_sym_in;
      hold_sv_ff  <= hold_sv_in;
      hold_err_ff <= hold_err_in;
      rsp_sym_ff  <= rsp_sym_in;
      rsp_sv_ff   <= rsp_sv_in;
      rsp_done_ff <= rsp_done_in;
      rsp_err_ff  <= rsp_err_in;
   end

   assign req_chan.ready           = (state_ff == S_IDLE);
   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.out_symbol      = rsp_sym_ff;
   assign rsp_chan.symbol_valid    = rsp_sv_ff;
   assign rsp_chan.expression_done = rsp_done_ff;
   assign rsp_chan.error_code      = rsp_err_ff;

endmodule

@@ rtl/core/infix_to_postfix_converter.sv @@
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Path: a request word is registered on acceptance; a letter's result word
// then moves to a hold stage and on to the response register. Each word
// waits in the hold stage until the next word is produced or the step ends.
// Flow: a request word is taken only in the idle state, after all steps for
// the previous word, with the stack flush on an end flag; the shift-register
// stack moves one entry a cycle, and output back-pressure stalls the steps.
// Reset (synchronous): stack empty, no result pending, ready for a word.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter #(
   parameter int STACK_DEPTH = i2p_pkg::STACK_DEPTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   i2p_req_if.sink   req_chan,
   i2p_rsp_if.source rsp_chan
);
   import i2p_pkg::*;

   stack_cmd_type stack_cmd;
   op_code_type   cell_value [STACK_DEPTH];

   i2p_ctrl #(
      .STACK_DEPTH (STACK_DEPTH)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .stack_top (cell_value[0]),
      .stack_cmd (stack_cmd)
   );

   for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
      op_code_type above;
      op_code_type below;

      if (i == 0) begin : g_top
         assign above = stack_cmd.code;
      end else begin : g_inner_above
         assign above = cell_value[i-1];
      end

      if (i == STACK_DEPTH - 1) begin : g_bottom
         assign below = CODE_OPEN;
      end else begin : g_inner_below
         assign below = cell_value[i+1];
      end

      i2p_cell u_cell (
         .clock      (clock),
         .stack_cmd  (stack_cmd),
         .from_above (above),
         .from_below (below),
         .value      (cell_value[i])
      );
   end

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Checks the infix to postfix converter word by word. A driver feeds infix
// characters from a queue and a monitor predicts the postfix words with its
// own operator stack, then compares every result word in order. Directed
// expressions come first, then random expressions that are mostly well formed,
// mixed with deep nesting to overflow, broken expressions and byte noise. Both
// channels idle and stall at random in the first two of three phases.
// ----------------------------------------------------------------------------
module testbench;
   import i2p_pkg::*;

   localparam int STACK_DEPTH  = STACK_DEPTH_DEFAULT;
   localparam int TARGET_WORDS = 420;
   localparam int STALL_LIMIT  = 4000;
   localparam int DRAIN_CYCLES = 64;

   localparam logic [5:0][7:0] OP_CHAR =
      {CHR_CARET, CHR_SLASH, CHR_STAR, CHR_MINUS, CHR_PLUS, CHR_OPEN};
   localparam logic [5:0][1:0] OP_RANK = {2'd3, 2'd2, 2'd2, 2'd1, 2'd1, 2'd0};

   typedef struct packed {
      logic [7:0] chr;
      logic       last;
   } infix_word_type;

   typedef struct packed {
      logic [7:0]   sym;
      logic         valid;
      logic         done;
      err_code_type err;
   } postfix_word_type;

   logic clock;
   logic reset;

   i2p_req_if req_chan ();
   i2p_rsp_if rsp_chan ();

   infix_to_postfix_converter i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   infix_word_type   stimulus_words[$];
   logic [7:0]       expr_text[$];
   postfix_word_type step_words[$];
   postfix_word_type postfix_expected[$];

   op_code_type op_stack [STACK_DEPTH];
   int          stack_fill;

   int   total_words;
   int   words_accepted;
   int   results_seen;
   int   expressions_done;
   int   mismatches;
   int   idle_cycles;
   int   err_tally [8];
   logic req_fire;

   initial clock = 1'b0;
   always #4 clock = ~clock;

   function automatic postfix_word_type make_word(logic [7:0] sym, logic valid,
                                                  err_code_type err);
      postfix_word_type w;
      w.sym   = sym;
      w.valid = valid;
      w.done  = 1'b0;
      w.err   = err;
      return w;
   endfunction

   function automatic void stack_push(op_code_type code);
      if (stack_fill >= STACK_DEPTH) begin
         step_words.push_back(make_word(CHR_NUL, 1'b0, ERR_OVERFLOW));
      end else begin
         op_stack[stack_fill] = code;
         stack_fill++;
      end
   endfunction

   function automatic void predict_postfix(logic [7:0] chr, logic last);
      op_code_type code;
      logic        is_op;
      logic        matched;
      logic        open_left;
      step_words = {};
      is_op = 1'b1;
      code  = CODE_OPEN;
      case (chr)
         CHR_PLUS:  code = CODE_PLUS;
         CHR_MINUS: code = CODE_MINUS;
         CHR_STAR:  code = CODE_MUL;
         CHR_SLASH: code = CODE_DIV;
         CHR_CARET: code = CODE_POW;
         default:   is_op = 1'b0;
      endcase
      if ((chr >= CHR_LOWER_A && chr <= CHR_LOWER_Z) ||
          (chr >= CHR_UPPER_A && chr <= CHR_UPPER_Z)) begin
         step_words.push_back(make_word(chr, 1'b1, ERR_NONE));
      end else if (chr == CHR_OPEN) begin
         stack_push(CODE_OPEN);
      end else if (chr == CHR_CLOSE) begin
         matched = 1'b0;
         while (stack_fill > 0 && !matched) begin
            stack_fill--;
            if (op_stack[stack_fill] == CODE_OPEN) begin
               matched = 1'b1;
            end else begin
               step_words.push_back(make_word(OP_CHAR[op_stack[stack_fill]], 1'b1,
                                              ERR_NONE));
            end
         end
         if (!matched) begin
            step_words.push_back(make_word(CHR_NUL, 1'b0, ERR_UNMATCHED_CLOSE));
         end
      end else if (is_op) begin
         while (stack_fill > 0 && op_stack[stack_fill-1] != CODE_OPEN &&
                OP_RANK[op_stack[stack_fill-1]] >= OP_RANK[code]) begin
            stack_fill--;
            step_words.push_back(make_word(OP_CHAR[op_stack[stack_fill]], 1'b1, ERR_NONE));
         end
         stack_push(code);
      end else begin
         step_words.push_back(make_word(CHR_NUL, 1'b0, ERR_UNKNOWN));
      end
      if (last) begin
         open_left = 1'b0;
         while (stack_fill > 0) begin
            stack_fill--;
            if (op_stack[stack_fill] == CODE_OPEN) begin
               open_left = 1'b1;
            end else begin
               step_words.push_back(make_word(OP_CHAR[op_stack[stack_fill]], 1'b1,
                                              ERR_NONE));
            end
         end
         if (open_left) begin
            step_words.push_back(make_word(CHR_NUL, 1'b0, ERR_UNCLOSED_OPEN));
         end
         if (step_words.size() == 0) begin
            step_words.push_back(make_word(CHR_NUL, 1'b0, ERR_NONE));
         end
         step_words[step_words.size()-1].done = 1'b1;
      end
      foreach (step_words[i]) begin
         postfix_expected.push_back(step_words[i]);
      end
   endfunction

   function automatic logic [7:0] random_letter();
      return ($urandom_range(0, 1) ? CHR_LOWER_A : CHR_UPPER_A) +
             8'($urandom_range(0, 25));
   endfunction

   function automatic logic [7:0] random_operator();
      return OP_CHAR[$urandom_range(1, 5)];
   endfunction

   function automatic void add_operand(int unsigned nest);
      if (nest < 4 && $urandom_range(0, 3) == 0) begin
         expr_text.push_back(CHR_OPEN);
         add_infix(nest + 1);
         expr_text.push_back(CHR_CLOSE);
      end else begin
         expr_text.push_back(random_letter());
      end
   endfunction

   function automatic void add_infix(int unsigned nest);
      int unsigned terms;
      terms = $urandom_range(1, 4);
      add_operand(nest);
      for (int unsigned i = 1; i < terms; i++) begin
         expr_text.push_back(random_operator());
         add_operand(nest);
      end
   endfunction

   function automatic void append_string(string s);
      for (int i = 0; i < s.len(); i++) begin
         expr_text.push_back(s[i]);
      end
   endfunction

   function automatic void queue_expression();
      infix_word_type w;
      foreach (expr_text[i]) begin
         w.chr  = expr_text[i];
         w.last = (i == expr_text.size() - 1);
         stimulus_words.push_back(w);
      end
      expr_text = {};
   endfunction

   function automatic void log_mismatch(string msg);
      mismatches++;
      if (mismatches <= 10) begin
         $display("mismatch %0d: %s", mismatches, msg);
      end
   endfunction

   // driver
   always @(negedge clock) begin
      infix_word_type next_word;
      int             send_idle;
      int             recv_stall;
      if (words_accepted * 3 < total_words) begin
         send_idle  = 23;
         recv_stall = 83;
      end else if (words_accepted * 3 < total_words * 2) begin
         send_idle  = 83;
         recv_stall = 23;
      end else begin
         send_idle  = 0;
         recv_stall = 0;
      end
      if (reset) begin
         req_chan.valid <= 1'b0;
         rsp_chan.ready <= 1'b0;
      end else begin
         if (!req_chan.valid || req_fire) begin
            if (stimulus_words.size() != 0 && $urandom_range(0, 99) >= send_idle) begin
               next_word = stimulus_words.pop_front();
               req_chan.valid             <= 1'b1;
               req_chan.symbol            <= next_word.chr;
               req_chan.end_of_expression <= next_word.last;
            end else begin
               req_chan.valid <= 1'b0;
            end
         end
         rsp_chan.ready <= ($urandom_range(0, 99) >= recv_stall);
      end
   end

   // monitor
   always @(posedge clock) begin
      postfix_word_type want;
      if (reset) begin
         req_fire   <= 1'b0;
         stack_fill = 0;
      end else begin
         req_fire <= req_chan.valid && req_chan.ready;
         if (req_chan.valid && req_chan.ready) begin
            predict_postfix(req_chan.symbol, req_chan.end_of_expression);
            words_accepted++;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            results_seen++;
            err_tally[rsp_chan.error_code]++;
            if (rsp_chan.expression_done) begin
               expressions_done++;
            end
            if (postfix_expected.size() == 0) begin
               log_mismatch($sformatf("unexpected word sym %02h valid %0b done %0b err %0d",
                                      rsp_chan.out_symbol, rsp_chan.symbol_valid,
                                      rsp_chan.expression_done, rsp_chan.error_code));
            end else begin
               want = postfix_expected.pop_front();
               if (rsp_chan.out_symbol !== want.sym ||
                   rsp_chan.symbol_valid !== want.valid ||
                   rsp_chan.expression_done !== want.done ||
                   rsp_chan.error_code !== want.err) begin
                  log_mismatch($sformatf({"expected sym %02h valid %0b done %0b err %0d,",
                                          " got sym %02h valid %0b done %0b err %0d"},
                                         want.sym, want.valid, want.done, want.err,
                                         rsp_chan.out_symbol, rsp_chan.symbol_valid,
                                         rsp_chan.expression_done, rsp_chan.error_code));
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("stalled for %0d cycles with %0d words outstanding",
                  idle_cycles, postfix_expected.size());
         $display("FAIL infix_to_postfix_converter");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int directed_words;
      int unsigned expr_index;
      int unsigned choice;
      int unsigned depth;
      reset                      = 1'b1;
      req_chan.valid             = 1'b0;
      req_chan.symbol            = CHR_NUL;
      req_chan.end_of_expression = 1'b0;
      rsp_chan.ready             = 1'b0;
      req_fire                   = 1'b0;
      stack_fill                 = 0;
      total_words                = 0;
      words_accepted             = 0;
      results_seen               = 0;
      expressions_done           = 0;
      mismatches                 = 0;
      idle_cycles                = 0;
      foreach (err_tally[i]) err_tally[i] = 0;

      append_string("a*(z+B)^Z");
      queue_expression();
      append_string("x/y-w");
      queue_expression();
      append_string("@[`{");
      expr_text.push_back(8'h00);
      expr_text.push_back(8'hFF);
      queue_expression();
      append_string(")");
      queue_expression();
      append_string("(a");
      queue_expression();
      append_string("()");
      queue_expression();
      directed_words = stimulus_words.size();

      expr_index = 0;
      while (stimulus_words.size() < TARGET_WORDS) begin
         choice = $urandom_range(0, 99);
         if (expr_index % 15 == 7) begin
            // nest deep enough to hit a full stack on some runs of opens
            depth = $urandom_range(STACK_DEPTH - 4, STACK_DEPTH + 4);
            repeat (depth) expr_text.push_back(CHR_OPEN);
            expr_text.push_back(random_letter());
            expr_text.push_back(random_operator());
            expr_text.push_back(random_letter());
            repeat ($urandom_range(0, depth)) expr_text.push_back(CHR_CLOSE);
         end else if (choice < 72) begin
            add_infix(0);
         end else if (choice < 86) begin
            add_infix(0);
            case ($urandom_range(0, 2))
               0: expr_text.delete($urandom_range(0, expr_text.size() - 1));
               1: expr_text.insert($urandom_range(0, expr_text.size()),
                                   $urandom_range(0, 1) ? CHR_OPEN : CHR_CLOSE);
               default: expr_text[$urandom_range(0, expr_text.size() - 1)] =
                           8'($urandom_range(0, 255));
            endcase
         end else begin
            repeat ($urandom_range(1, 8)) expr_text.push_back(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1)) begin
               expr_text.push_back(random_operator());
            end
         end
         if (choice >= 94 && expr_text.size() > 1) begin
            // split: an early end partway through the noise
            stimulus_words.push_back('{expr_text.pop_front(), 1'b1});
         end
         queue_expression();
         expr_index++;
      end
      total_words = stimulus_words.size();

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (stimulus_words.size() != 0 || req_chan.valid) @(negedge clock);
      while (postfix_expected.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      while (postfix_expected.size() != 0) begin
         void'(postfix_expected.pop_front());
         log_mismatch("expected word never arrived");
      end

      $display("sent %0d infix words (%0d directed), got %0d postfix words over %0d expressions",
               words_accepted, directed_words, results_seen, expressions_done);
      $display("error words: unmatched close %0d, overflow %0d, unknown %0d, unclosed open %0d",
               err_tally[ERR_UNMATCHED_CLOSE], err_tally[ERR_OVERFLOW],
               err_tally[ERR_UNKNOWN], err_tally[ERR_UNCLOSED_OPEN]);
      if (mismatches == 0) begin
         $display("PASS infix_to_postfix_converter");
      end else begin
         $display("%0d mismatches in total", mismatches);
         $display("FAIL infix_to_postfix_converter");
      end
      $finish;
   end

endmodule

@@ files.f @@
rtl/core/i2p_pkg.sv
rtl/core/i2p_req_if.sv
rtl/core/i2p_rsp_if.sv
rtl/core/i2p_cell.sv
rtl/core/i2p_ctrl.sv
rtl/core/infix_to_postfix_converter.sv
tb/testbench.sv
